@@ hw/rtl/mqb_pkg.sv @@
// Shared constants and controller/datapath handshake types for the MIME line decoder.
package mqb_pkg;

   localparam int LA_DEPTH = 10;
   localparam int LA_IDX_W = $clog2(LA_DEPTH);
   localparam int LA_CNT_W = $clog2(LA_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_STORE = 3'd1,
      OP_PASS  = 3'd2,
      OP_FEED  = 3'd3,
      OP_FLUSH = 3'd4,
      OP_DEC   = 3'd5,
      OP_FINAL = 3'd6
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                accept;
      logic                first;
      logic                src_buf;
      logic [LA_IDX_W-1:0] rel_idx;
      logic [LA_CNT_W-1:0] store_idx;
      logic [1:0]          dec_idx;
      logic                b64_off;
      logic                line_en;
   } cmd_type;

   typedef struct packed {
      logic replay;
      logic qfull;
      logic dec_stop;
      logic byte_bad;
      logic pend;
      logic last;
      logic nob;
      logic out_free;
   } status_type;

endpackage

@@ hw/rtl/mqb_if.sv @@
// Valid/ready channel interfaces for requests, responses and the control register.
interface mqb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;
   logic       no_byte;
   logic       preset_valid;
   logic       preset_qp;
   logic       preset_b64;
   modport source (output valid, data_byte, last, no_byte, preset_valid, preset_qp,
                   preset_b64, input ready);
   modport sink (input valid, data_byte, last, no_byte, preset_valid, preset_qp,
                 preset_b64, output ready);
endinterface

interface mqb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic       out_none;
   modport source (output valid, out_byte, out_last, out_none, input ready);
   modport sink (input valid, out_byte, out_last, out_none, output ready);
endinterface

interface mqb_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/mqb_datapath.sv @@
// Decoder datapath: lookahead buffer, parser state, quartet decode, held byte and output register.
module mqb_datapath
   import mqb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   input  logic       req_no_byte,
   input  logic       req_preset_valid,
   input  logic       req_preset_qp,
   input  logic       req_preset_b64,
   input  cmd_type    cmd,
   output status_type st,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic       rsp_out_none
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_QMARK, PH_QMARK_EQ, PH_EQ, PH_SCAN, PH_QP_HI, PH_QP_LO, PH_B64
   } phase_type;

   localparam logic [7:0] CH_QM = 8'h3F;
   localparam logic [7:0] CH_EQ = 8'h3D;
   localparam logic [7:0] CH_SP = 8'h20;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_Q  = 8'h71;
   localparam logic [7:0] CH_B  = 8'h62;

   function automatic logic [7:0] b64val(input logic [7:0] c);
      logic [7:0] r;
      r = 8'hFF;
      if (c >= 8'h41 && c <= 8'h5A) r = c - 8'h41;
      else if (c >= 8'h61 && c <= 8'h7A) r = c - 8'h61 + 8'd26;
      else if (c >= 8'h30 && c <= 8'h39) r = c - 8'h30 + 8'd52;
      else if (c == 8'h2B) r = 8'd62;
      else if (c == 8'h2F) r = 8'd63;
      return r;
   endfunction

   // bit 4 flags an invalid digit
   function automatic logic [4:0] hexval(input logic [7:0] c);
      logic [7:0] r;
      logic [4:0] v;
      r = 8'h00;
      v = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = c - 8'h30;
         v = {1'b0, r[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = c - 8'h61 + 8'd10;
         v = {1'b0, r[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = c - 8'h41 + 8'd10;
         v = {1'b0, r[3:0]};
      end
      return v;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SP) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   logic [7:0]       byte_ff;
   logic             last_ff, nob_ff;
   logic [7:0]       buf_ff [LA_DEPTH];
   logic             qp_ff, qp_in, b64_ff, b64_in, fin_ff, fin_in;
   phase_type        phase_ff, phase_in;
   logic [3:0][7:0]  chars_ff, chars_in;
   logic [1:0]       fill_ff, fill_in;
   logic [1:0]       qm_ff, qm_in;
   logic [7:0]       kind_ff, kind_in;
   logic [3:0]       hi_ff, hi_in;
   logic             held_v_ff, held_v_in;
   logic [7:0]       held_b_ff, held_b_in;
   logic             out_v_ff, out_v_in;
   logic [7:0]       out_b_ff, out_b_in;
   logic             out_l_ff, out_l_in, out_n_ff, out_n_in;

   logic [7:0] sym, top_sym, push_c, prod_b, fin_b;
   logic [7:0] qa, qb, qc, qd;
   logic [4:0] hv;
   logic [7:0] qp_byte;
   logic [1:0] push_idx;
   logic       top_en, push_en, prod, out_load, replay, qfull, dec_stop;

   assign sym = cmd.src_buf ? buf_ff[cmd.rel_idx] : byte_ff;
   assign qa  = b64val(chars_ff[0]);
   assign qb  = b64val(chars_ff[1]);
   assign qc  = b64val(chars_ff[2]);
   assign qd  = b64val(chars_ff[3]);
   assign hv  = hexval(sym);
   assign qp_byte = {hi_ff, hv[3:0]};

   always_comb begin
      qp_in = qp_ff; b64_in = b64_ff; fin_in = fin_ff; phase_in = phase_ff;
      chars_in = chars_ff; fill_in = fill_ff; qm_in = qm_ff; kind_in = kind_ff;
      hi_in = hi_ff; held_v_in = held_v_ff; held_b_in = held_b_ff;
      out_b_in = out_b_ff; out_l_in = out_l_ff; out_n_in = out_n_ff;
      top_en = 1'b0; top_sym = 8'h00; push_en = 1'b0; push_c = 8'h00; push_idx = fill_ff;
      prod = 1'b0; prod_b = 8'h00; out_load = 1'b0; replay = 1'b0; qfull = 1'b0;
      dec_stop = 1'b0; fin_b = held_b_ff;

      if (cmd.accept && cmd.first && req_preset_valid) begin
         qp_in  = req_preset_qp;
         b64_in = req_preset_b64;
      end
      if (cmd.b64_off) b64_in = 1'b0;

      case (cmd.op)
         OP_PASS: begin
            prod = 1'b1;
            prod_b = byte_ff;
         end
         OP_FEED: begin
            case (phase_ff)
               PH_IDLE: begin
                  if (sym == CH_QM) phase_in = PH_QMARK;
                  else if (sym == CH_EQ) phase_in = PH_EQ;
                  else begin
                     top_en = 1'b1;
                     top_sym = sym;
                  end
               end
               PH_QMARK: begin
                  if (sym == CH_EQ) phase_in = PH_QMARK_EQ;
                  else begin
                     phase_in = PH_IDLE;
                     top_en = 1'b1;
                     top_sym = CH_QM;
                     replay = 1'b1;
                  end
               end
               PH_QMARK_EQ: begin
                  if (sym == CH_SP) begin
                     qp_in = 1'b0;
                     b64_in = 1'b0;
                     phase_in = PH_IDLE;
                     prod = 1'b1;
                     prod_b = CH_SP;
                  end else begin
                     phase_in = PH_EQ;
                     replay = 1'b1;
                  end
               end
               PH_EQ: begin
                  if (sym == CH_QM) begin
                     phase_in = PH_SCAN;
                     qm_in = 2'd1;
                     kind_in = 8'h00;
                  end else begin
                     phase_in = PH_IDLE;
                     top_en = 1'b1;
                     top_sym = CH_EQ;
                     replay = 1'b1;
                  end
               end
               PH_SCAN: begin
                  if (sym == CH_QM) begin
                     if (qm_ff >= 2'd2) begin
                        if (kind_ff == CH_Q) qp_in = 1'b1;
                        else if (kind_ff == CH_B) b64_in = 1'b1;
                        phase_in = PH_IDLE;
                     end else begin
                        qm_in = qm_ff + 2'd1;
                     end
                  end else if (qm_ff == 2'd2) begin
                     kind_in = sym | 8'h20;
                  end
               end
               PH_QP_HI: begin
                  hi_in = hv[4] ? 4'hF : hv[3:0];
                  phase_in = PH_QP_LO;
               end
               PH_QP_LO: begin
                  phase_in = PH_IDLE;
                  if (!hv[4] && qp_byte != 8'hFF) begin
                     prod = 1'b1;
                     prod_b = qp_byte;
                  end
               end
               PH_B64: begin
                  if (!is_space(sym)) begin
                     push_en = 1'b1;
                     push_c = sym;
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
         end
         OP_FLUSH: begin
            phase_in = PH_IDLE;
            top_en = 1'b1;
            top_sym = (phase_ff == PH_QMARK) ? CH_QM : CH_EQ;
         end
         OP_DEC: begin
            case (cmd.dec_idx)
               2'd0: begin
                  if (chars_ff[0] == CH_EQ || chars_ff[1] == CH_EQ) begin
                     fin_in = 1'b1;
                     dec_stop = 1'b1;
                  end else begin
                     prod = 1'b1;
                     prod_b = {qa[5:0], qb[5:4]};
                  end
               end
               2'd1: begin
                  if (chars_ff[2] == CH_EQ) begin
                     fin_in = 1'b1;
                     dec_stop = 1'b1;
                  end else begin
                     prod = 1'b1;
                     prod_b = {qb[3:0], qc[5:2]};
                  end
               end
               default: begin
                  dec_stop = 1'b1;
                  if (chars_ff[3] == CH_EQ) fin_in = 1'b1;
                  else begin
                     prod = 1'b1;
                     // an invalid last symbol sets every bit
                     prod_b = {qc[1:0], 6'h00} | qd;
                  end
               end
            endcase
            if (dec_stop) begin
               chars_in = '0;
               fill_in = 2'd0;
               phase_in = PH_IDLE;
            end
         end
         OP_FINAL: begin
            out_load = 1'b1;
            out_l_in = 1'b1;
            if (held_v_ff) begin
               if (cmd.line_en && !b64_ff && held_b_ff == CH_EQ) fin_b = CH_LF;
               out_b_in = fin_b;
               out_n_in = 1'b0;
            end else begin
               out_b_in = 8'h00;
               out_n_in = 1'b1;
            end
            held_v_in = 1'b0;
            phase_in = PH_IDLE;
            chars_in = '0;
            fill_in = 2'd0;
            qm_in = 2'd0;
            kind_in = 8'h00;
            hi_in = 4'h0;
            fin_in = 1'b0;
         end
         default: ;
      endcase

      if (top_en) begin
         if (top_sym == CH_LF) begin
            if (!b64_ff) begin
               prod = 1'b1;
               prod_b = CH_LF;
            end
            fin_in = 1'b0;
            qp_in = 1'b0;
            b64_in = 1'b0;
         end else if (qp_ff && top_sym == CH_EQ) begin
            phase_in = PH_QP_HI;
         end else if (b64_ff && !fin_ff) begin
            fill_in = 2'd0;
            chars_in = '0;
            phase_in = PH_B64;
            push_idx = 2'd0;
            if (!is_space(top_sym)) begin
               push_en = 1'b1;
               push_c = top_sym;
            end
         end else begin
            prod = 1'b1;
            prod_b = top_sym;
         end
      end

      if (push_en) begin
         chars_in[push_idx] = push_c;
         fill_in = push_idx + 2'd1;
         qfull = (push_idx == 2'd3);
      end

      if (prod) begin
         if (held_v_ff) begin
            out_load = 1'b1;
            out_b_in = held_b_ff;
            out_l_in = 1'b0;
            out_n_in = 1'b0;
         end
         held_v_in = 1'b1;
         held_b_in = prod_b;
      end

      if (out_load) out_v_in = 1'b1;
      else if (rsp_ready) out_v_in = 1'b0;
      else out_v_in = out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         byte_ff <= req_data_byte;
         last_ff <= req_last;
         nob_ff  <= req_no_byte;
      end
      if (cmd.op == OP_STORE) buf_ff[cmd.store_idx[LA_IDX_W-1:0]] <= byte_ff;
      held_b_ff <= held_b_in;
      out_b_ff  <= out_b_in;
      out_l_ff  <= out_l_in;
      out_n_ff  <= out_n_in;
      if (reset) begin
         qp_ff <= 1'b0;
         b64_ff <= 1'b0;
         fin_ff <= 1'b0;
         phase_ff <= PH_IDLE;
         chars_ff <= '0;
         fill_ff <= 2'd0;
         qm_ff <= 2'd0;
         kind_ff <= 8'h00;
         hi_ff <= 4'h0;
         held_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         qp_ff <= qp_in;
         b64_ff <= b64_in;
         fin_ff <= fin_in;
         phase_ff <= phase_in;
         chars_ff <= chars_in;
         fill_ff <= fill_in;
         qm_ff <= qm_in;
         kind_ff <= kind_in;
         hi_ff <= hi_in;
         held_v_ff <= held_v_in;
         out_v_ff <= out_v_in;
      end
   end

   assign st.replay   = replay;
   assign st.qfull    = qfull;
   assign st.dec_stop = dec_stop;
   assign st.byte_bad = (b64val(byte_ff) == 8'hFF);
   assign st.pend     = (phase_ff == PH_QMARK) || (phase_ff == PH_QMARK_EQ) ||
                        (phase_ff == PH_EQ);
   assign st.last     = last_ff;
   assign st.nob      = nob_ff;
   assign st.out_free = !out_v_ff || rsp_ready;

   assign rsp_valid    = out_v_ff;
   assign rsp_out_byte = out_b_ff;
   assign rsp_out_last = out_l_ff;
   assign rsp_out_none = out_n_ff;

endmodule

@@ hw/rtl/mqb_ctrl.sv @@
// Decoder controller: line bookkeeping, lookahead release sequencing and step issue.
module mqb_ctrl
   import mqb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data,
   input  status_type st,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_DISP, S_FEED, S_DEC, S_PASS, S_END, S_PEND, S_FINAL
   } state_type;

   state_type           state_ff, state_in;
   logic                enable_ff, enable_in;
   logic                line_open_ff, line_open_in;
   logic                line_en_ff, line_en_in;
   logic                checked_ff, checked_in;
   logic [LA_CNT_W-1:0] la_count_ff, la_count_in, la_next, rel_next;
   logic [LA_IDX_W-1:0] rel_idx_ff, rel_idx_in;
   logic                src_buf_ff, src_buf_in;
   logic                byte_pend_ff, byte_pend_in;
   logic                in_end_ff, in_end_in;
   logic [1:0]          dec_idx_ff, dec_idx_in;
   logic                sym_done;

   assign csr_ready = 1'b1;
   assign la_next   = la_count_ff + LA_CNT_W'(1);
   assign rel_next  = LA_CNT_W'(rel_idx_ff) + LA_CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      enable_in = (csr_valid) ? csr_data : enable_ff;
      line_open_in = line_open_ff;
      line_en_in = line_en_ff;
      checked_in = checked_ff;
      la_count_in = la_count_ff;
      rel_idx_in = rel_idx_ff;
      src_buf_in = src_buf_ff;
      byte_pend_in = byte_pend_ff;
      in_end_in = in_end_ff;
      dec_idx_in = dec_idx_ff;
      sym_done = 1'b0;
      req_ready = 1'b0;
      cmd = '0;
      cmd.src_buf = src_buf_ff;
      cmd.rel_idx = rel_idx_ff;
      cmd.store_idx = la_count_ff;
      cmd.dec_idx = dec_idx_ff;
      cmd.line_en = line_en_ff;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               cmd.first = !line_open_ff;
               if (!line_open_ff) begin
                  line_open_in = 1'b1;
                  line_en_in = enable_ff;
                  checked_in = !enable_ff;
                  la_count_in = '0;
                  in_end_in = 1'b0;
               end
               byte_pend_in = 1'b0;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (st.nob) state_in = S_END;
            else if (!line_en_ff) state_in = S_PASS;
            else if (checked_ff) begin
               src_buf_in = 1'b0;
               state_in = S_FEED;
            end else if (st.byte_bad) begin
               cmd.b64_off = 1'b1;
               checked_in = 1'b1;
               byte_pend_in = 1'b1;
               src_buf_in = (la_count_ff != '0);
               rel_idx_in = '0;
               state_in = S_FEED;
            end else begin
               cmd.op = OP_STORE;
               la_count_in = la_next;
               if (la_next == LA_CNT_W'(LA_DEPTH)) begin
                  checked_in = 1'b1;
                  src_buf_in = 1'b1;
                  rel_idx_in = '0;
                  state_in = S_FEED;
               end else begin
                  state_in = S_END;
               end
            end
         end
         S_FEED: begin
            if (st.out_free) begin
               cmd.op = OP_FEED;
               if (st.qfull) begin
                  dec_idx_in = 2'd0;
                  state_in = S_DEC;
               end else if (!st.replay) begin
                  sym_done = 1'b1;
               end
            end
         end
         S_DEC: begin
            if (st.out_free) begin
               cmd.op = OP_DEC;
               if (st.dec_stop) sym_done = 1'b1;
               else dec_idx_in = dec_idx_ff + 2'd1;
            end
         end
         S_PASS: begin
            if (st.out_free) begin
               cmd.op = OP_PASS;
               state_in = S_END;
            end
         end
         S_END: begin
            if (!st.last) state_in = S_IDLE;
            else if (line_en_ff && !checked_ff) begin
               cmd.b64_off = 1'b1;
               checked_in = 1'b1;
               in_end_in = 1'b1;
               if (la_count_ff != '0) begin
                  src_buf_in = 1'b1;
                  rel_idx_in = '0;
                  state_in = S_FEED;
               end else begin
                  state_in = S_PEND;
               end
            end else begin
               state_in = S_PEND;
            end
         end
         S_PEND: begin
            if (line_en_ff && st.pend) begin
               if (st.out_free) begin
                  cmd.op = OP_FLUSH;
                  state_in = S_FINAL;
               end
            end else begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            if (st.out_free) begin
               cmd.op = OP_FINAL;
               line_open_in = 1'b0;
               checked_in = 1'b0;
               la_count_in = '0;
               in_end_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (sym_done) begin
         state_in = S_FEED;
         if (src_buf_ff) begin
            if (rel_next < la_count_ff) begin
               rel_idx_in = rel_next[LA_IDX_W-1:0];
            end else begin
               la_count_in = '0;
               src_buf_in = 1'b0;
               if (byte_pend_ff) byte_pend_in = 1'b0;
               else if (in_end_ff) state_in = S_PEND;
               else state_in = S_END;
            end
         end else begin
            state_in = S_END;
         end
      end
   end

   always_ff @(posedge clock) begin
      rel_idx_ff <= rel_idx_in;
      dec_idx_ff <= dec_idx_in;
      if (reset) begin
         state_ff <= S_IDLE;
         enable_ff <= 1'b1;
         line_open_ff <= 1'b0;
         line_en_ff <= 1'b1;
         checked_ff <= 1'b0;
         la_count_ff <= '0;
         src_buf_ff <= 1'b0;
         byte_pend_ff <= 1'b0;
         in_end_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         enable_ff <= enable_in;
         line_open_ff <= line_open_in;
         line_en_ff <= line_en_in;
         checked_ff <= checked_in;
         la_count_ff <= la_count_in;
         src_buf_ff <= src_buf_in;
         byte_pend_ff <= byte_pend_in;
         in_end_ff <= in_end_in;
      end
   end

   a_pass_checked: assert property (@(posedge clock) disable iff (reset)
      (line_open_ff && !line_en_ff) |-> checked_ff)
      else $error("pass-through line not marked checked");
   a_la_bound: assert property (@(posedge clock) disable iff (reset)
      la_count_ff <= LA_CNT_W'(LA_DEPTH))
      else $error("lookahead count overflow");
   a_final_close: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FINAL) |=> !line_open_ff)
      else $error("line still open after final transfer");
   a_rel_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FEED && src_buf_ff) |-> (LA_CNT_W'(rel_idx_ff) < la_count_ff))
      else $error("release index beyond lookahead fill");

endmodule

@@ hw/rtl/mime_qp_base64_line_decoder_top.sv @@
// Top level of the MIME quoted-printable / base64 line decoder.
// A decoded byte takes longer for each feed step, replayed pending '?'/'=' symbol and decoded
// quartet byte. Items are taken one at a time; lookahead release and quartet output bursts run
// one step per cycle while the output register is free, and each output transfer waits on it.
// Reset: synchronous, active high; clears modes and parser, decode_enable returns to 1.
module mime_qp_base64_line_decoder_top
   import mqb_pkg::*;
(
   input logic     clock,
   input logic     reset,
   mqb_req_if.sink   req_ch,
   mqb_rsp_if.source rsp_ch,
   mqb_csr_if.sink   csr_ch
);

   cmd_type    cmd;
   status_type st;

   mqb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ch.ready),
      .csr_data  (csr_ch.data),
      .st        (st),
      .cmd       (cmd)
   );

   mqb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data_byte    (req_ch.data_byte),
      .req_last         (req_ch.last),
      .req_no_byte      (req_ch.no_byte),
      .req_preset_valid (req_ch.preset_valid),
      .req_preset_qp    (req_ch.preset_qp),
      .req_preset_b64   (req_ch.preset_b64),
      .cmd              (cmd),
      .st               (st),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_out_byte     (rsp_ch.out_byte),
      .rsp_out_last     (rsp_ch.out_last),
      .rsp_out_none     (rsp_ch.out_none)
   );

endmodule

@@ sim/tb_mime_qp_base64_line_decoder_top.sv @@
// Testbench for the MIME QP/base64 line decoder: random lines, self-predicting scoreboard.
`timescale 1ns / 100ps

module tb_mime_qp_base64_line_decoder_top;
   import mqb_pkg::*;

   localparam int LOOK_LEN = 10;

   typedef enum int {
      PH_IDLE, PH_QMARK, PH_QMARK_EQ, PH_EQ, PH_SCAN, PH_QP_HI, PH_QP_LO, PH_B64
   } phase_t;

   typedef struct {
      bit [7:0] data_byte;
      bit       last;
      bit       no_byte;
      bit       preset_valid;
      bit       preset_qp;
      bit       preset_b64;
   } line_item_t;

   typedef struct {
      bit [7:0] out_byte;
      bit       out_last;
      bit       out_none;
   } dec_byte_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mqb_req_if req_ch ();
   mqb_rsp_if rsp_ch ();
   mqb_csr_if csr_ch ();

   mime_qp_base64_line_decoder_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always #5 clock = ~clock;

   line_item_t pending_bytes[$];
   dec_byte_t  decoded_q[$];
   line_item_t cur_item;
   int         err_cnt = 0;
   int         bytes_sent = 0;
   int         bytes_checked = 0;
   int         lines_sent = 0;
   int         tx_gap = 0;
   int         rx_stall = 0;
   bit         no_idle = 1'b0;
   bit         stim_done = 1'b0;

   // decoder shadow state
   bit         dec_enable;
   bit [7:0]   la_buf[LOOK_LEN];
   int         la_cnt;
   bit         qp_mode, b64_mode, b64_done;
   phase_t     phase;
   bit [31:0]  qchars;
   int         qfill;
   int         word_q;
   bit [7:0]   word_kind;
   bit [3:0]   qp_hi;
   bit [8:0]   held;
   bit         line_open, line_en, scanned;

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      err_cnt++;
   endtask

   function automatic void shadow_reset();
      dec_enable = 1'b1;
      la_cnt = 0;
      qp_mode = 0; b64_mode = 0; b64_done = 0;
      phase = PH_IDLE;
      qchars = 0; qfill = 0; word_q = 0; word_kind = 0; qp_hi = 0;
      held = 0;
      line_open = 0; line_en = 1; scanned = 0;
   endfunction

   function automatic void add_result(bit [7:0] b, bit lst, bit none);
      dec_byte_t r;
      r.out_byte = b; r.out_last = lst; r.out_none = none;
      decoded_q.push_back(r);
   endfunction

   function automatic void put_byte(bit [7:0] b);
      if (held[8]) add_result(held[7:0], 0, 0);
      held = {1'b1, b};
   endfunction

   function automatic bit [7:0] hex_digit(bit [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 8'd10;
      if (c >= "A" && c <= "F") return c - "A" + 8'd10;
      return 8'hFF;
   endfunction

   function automatic bit [7:0] b64_code(bit [7:0] c);
      if (c >= "A" && c <= "Z") return c - "A";
      if (c >= "a" && c <= "z") return c - "a" + 8'd26;
      if (c >= "0" && c <= "9") return c - "0" + 8'd52;
      if (c == "+") return 8'd62;
      if (c == "/") return 8'd63;
      return 8'hFF;
   endfunction

   function automatic bit white(bit [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic void quartet_out();
      bit [7:0] q0, q1, q2, q3, a, b, c;
      q0 = qchars[7:0]; q1 = qchars[15:8]; q2 = qchars[23:16]; q3 = qchars[31:24];
      if (q0 == "=" || q1 == "=") begin
         b64_done = 1; return;
      end
      a = b64_code(q0);
      b = b64_code(q1);
      put_byte((a << 2) | ((b & 8'h30) >> 4));
      if (q2 == "=") begin
         b64_done = 1; return;
      end
      c = b64_code(q2);
      put_byte(((b & 8'h0F) << 4) | ((c & 8'h3C) >> 2));
      if (q3 == "=") begin
         b64_done = 1; return;
      end
      put_byte(((c & 8'h03) << 6) | b64_code(q3));
   endfunction

   function automatic void quartet_add(bit [7:0] c);
      qchars |= 32'(c) << (8 * (qfill & 3));
      qfill++;
      if (qfill >= 4) begin
         quartet_out();
         qfill = 0; qchars = 0; phase = PH_IDLE;
      end
   endfunction

   function automatic void plain_sym(bit [7:0] c);
      if (c == 8'h0A) begin
         if (!b64_mode) put_byte(8'h0A);
         b64_done = 0; qp_mode = 0; b64_mode = 0;
         return;
      end
      if (qp_mode && c == "=") begin
         phase = PH_QP_HI; return;
      end
      if (b64_mode && !b64_done) begin
         qfill = 0; qchars = 0; phase = PH_B64;
         if (!white(c)) quartet_add(c);
         return;
      end
      put_byte(c);
   endfunction

   function automatic void parse_sym(bit [7:0] c);
      bit [7:0] v;
      case (phase)
         PH_IDLE: begin
            if (c == "?") phase = PH_QMARK;
            else if (c == "=") phase = PH_EQ;
            else plain_sym(c);
         end
         PH_QMARK: begin
            if (c == "=") phase = PH_QMARK_EQ;
            else begin
               phase = PH_IDLE; plain_sym("?"); parse_sym(c);
            end
         end
         PH_QMARK_EQ: begin
            phase = PH_IDLE;
            if (c == " ") begin
               qp_mode = 0; b64_mode = 0; plain_sym(" ");
            end else begin
               parse_sym("="); parse_sym(c);
            end
         end
         PH_EQ: begin
            if (c == "?") begin
               phase = PH_SCAN; word_q = 1; word_kind = 0;
            end else begin
               phase = PH_IDLE; plain_sym("="); parse_sym(c);
            end
         end
         PH_SCAN: begin
            if (c == "?") begin
               if (word_q >= 2) begin
                  if (word_kind == "q") qp_mode = 1;
                  else if (word_kind == "b") b64_mode = 1;
                  phase = PH_IDLE;
               end else word_q++;
            end else if (word_q == 2) word_kind = c | 8'h20;
         end
         PH_QP_HI: begin
            v = hex_digit(c);
            qp_hi = (v == 8'hFF) ? 4'hF : v[3:0];
            phase = PH_QP_LO;
         end
         PH_QP_LO: begin
            phase = PH_IDLE;
            v = hex_digit(c);
            if (v != 8'hFF && {qp_hi, v[3:0]} != 8'hFF) put_byte({qp_hi, v[3:0]});
         end
         PH_B64: if (!white(c)) quartet_add(c);
         default: phase = PH_IDLE;
      endcase
   endfunction

   function automatic void flush_lookahead();
      scanned = 1;
      for (int i = 0; i < la_cnt && i < LOOK_LEN; i++) parse_sym(la_buf[i]);
      la_cnt = 0;
   endfunction

   function automatic void close_line();
      bit [7:0] b;
      if (line_en) begin
         if (!scanned) begin
            b64_mode = 0; flush_lookahead();
         end
         if (phase == PH_QMARK) begin
            phase = PH_IDLE; plain_sym("?");
         end else if (phase == PH_QMARK_EQ || phase == PH_EQ) begin
            phase = PH_IDLE; plain_sym("=");
         end
      end
      if (held[8]) begin
         b = held[7:0];
         if (line_en && !b64_mode && b == "=") b = 8'h0A;
         add_result(b, 1, 0);
      end else add_result(0, 1, 1);
      held = 0; phase = PH_IDLE;
      qchars = 0; qfill = 0; word_q = 0; word_kind = 0; qp_hi = 0;
      b64_done = 0; la_cnt = 0; line_open = 0; scanned = 0;
   endfunction

   function automatic void decode_item(line_item_t it);
      if (!line_open) begin
         line_open = 1;
         line_en = dec_enable;
         if (it.preset_valid) begin
            qp_mode = it.preset_qp; b64_mode = it.preset_b64;
         end
         scanned = !line_en;
         la_cnt = 0;
      end
      if (!it.no_byte) begin
         if (!line_en) put_byte(it.data_byte);
         else if (scanned) parse_sym(it.data_byte);
         else if (b64_code(it.data_byte) == 8'hFF) begin
            b64_mode = 0; flush_lookahead(); parse_sym(it.data_byte);
         end else begin
            if (la_cnt < LOOK_LEN) la_buf[la_cnt] = it.data_byte;
            la_cnt++;
            if (la_cnt >= LOOK_LEN) flush_lookahead();
         end
      end
      if (it.last) close_line();
   endfunction

   function automatic int pick_gap();
      if (no_idle || $urandom_range(0, 2) != 0) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // request driver
   always @(posedge clock) begin : drive_req
      bit go;
      line_item_t it;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         go = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            decode_item(cur_item);
            bytes_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (tx_gap > 0) tx_gap--;
            else if (pending_bytes.size() > 0) begin
               it = pending_bytes.pop_front();
               cur_item = it;
               req_ch.data_byte    <= it.data_byte;
               req_ch.last         <= it.last;
               req_ch.no_byte      <= it.no_byte;
               req_ch.preset_valid <= it.preset_valid;
               req_ch.preset_qp    <= it.preset_qp;
               req_ch.preset_b64   <= it.preset_b64;
               go = 1'b1;
               tx_gap = pick_gap();
            end
            req_ch.valid <= go;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : watch_rsp
      dec_byte_t want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (decoded_q.size() == 0) report("unexpected transfer", rsp_ch.out_byte, 0);
            else begin
               want = decoded_q.pop_front();
               bytes_checked++;
               if (rsp_ch.out_byte !== want.out_byte)
                  report("out_byte", rsp_ch.out_byte, want.out_byte);
               if (rsp_ch.out_last !== want.out_last)
                  report("out_last", rsp_ch.out_last, want.out_last);
               if (rsp_ch.out_none !== want.out_none)
                  report("out_none", rsp_ch.out_none, want.out_none);
            end
         end
         if (rx_stall > 0) begin
            rx_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            rx_stall = pick_gap();
         end
      end
   end

   function automatic void queue_line(bit [7:0] txt[$], bit pv, bit pq, bit pb,
                                      bit mid_gaps);
      line_item_t it;
      lines_sent++;
      if (txt.size() == 0) begin
         it = '{0, 1, 1, pv, pq, pb};
         pending_bytes.push_back(it);
         return;
      end
      foreach (txt[i]) begin
         if (mid_gaps && $urandom_range(0, 5) == 0) begin
            it = '{8'($urandom), 0, 1, (i == 0) ? pv : 1'($urandom), pq, pb};
            pending_bytes.push_back(it);
         end
         it.data_byte = txt[i];
         it.last = (i == txt.size() - 1);
         it.no_byte = 0;
         it.preset_valid = (i == 0 && !mid_gaps) ? pv : 1'($urandom);
         it.preset_qp = pq;
         it.preset_b64 = pb;
         if (i == 0 && mid_gaps) it.preset_valid = pv;
         pending_bytes.push_back(it);
      end
   endfunction

   function automatic void queue_str(string s, bit pv, bit pq, bit pb);
      bit [7:0] txt[$];
      for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
      queue_line(txt, pv, pq, pb, 0);
   endfunction

   function automatic bit [7:0] b64_char();
      int k;
      k = $urandom_range(0, 63);
      if (k < 26) return 8'("A" + k);
      if (k < 52) return 8'("a" + k - 26);
      if (k < 62) return 8'("0" + k - 52);
      return (k == 62) ? "+" : "/";
   endfunction

   function automatic bit [7:0] hex_char();
      string h = "0123456789abcdefABCDEFZg";
      return h[$urandom_range(0, h.len() - 1)];
   endfunction

   function automatic void text_bytes(ref bit [7:0] txt[$], input int n);
      string pool = "ab xyz?=\n09";
      repeat (n) begin
         if ($urandom_range(0, 2) == 0) txt.push_back(pool[$urandom_range(0, pool.len() - 1)]);
         else txt.push_back(8'($urandom_range(32, 126)));
      end
   endfunction

   function automatic void random_line();
      bit [7:0] txt[$];
      string    opener;
      int       kind;
      kind = $urandom_range(0, 9);
      case (kind)
         0: begin
            repeat ($urandom_range(1, 12)) txt.push_back(8'($urandom));
            queue_line(txt, 1'($urandom), 1'($urandom), 1'($urandom), 1);
         end
         1, 2: begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 1)) begin
                  txt.push_back("="); txt.push_back(hex_char()); txt.push_back(hex_char());
               end else text_bytes(txt, $urandom_range(1, 3));
            end
            queue_line(txt, 1, 1, 0, $urandom_range(0, 3) == 0);
         end
         3, 4: begin
            repeat ($urandom_range(10, 20)) begin
               if (txt.size() >= 10 && $urandom_range(0, 7) == 0) txt.push_back(" ");
               else txt.push_back(b64_char());
            end
            if ($urandom_range(0, 2) == 0) txt.push_back("=");
            if ($urandom_range(0, 3) == 0) txt.push_back(8'h0A);
            queue_line(txt, 1, 1'($urandom), 1, 0);
         end
         5, 6: begin
            text_bytes(txt, $urandom_range(0, 2));
            opener = $urandom_range(0, 1) ? "=?cs?Q?" : "=?u8?b?";
            for (int i = 0; i < opener.len(); i++) txt.push_back(opener[i]);
            repeat ($urandom_range(2, 8)) begin
               if ($urandom_range(0, 4) == 0) begin
                  txt.push_back("="); txt.push_back(hex_char()); txt.push_back(hex_char());
               end else txt.push_back(b64_char());
            end
            if ($urandom_range(0, 2) != 0) begin
               txt.push_back("?"); txt.push_back("="); txt.push_back(" ");
            end
            text_bytes(txt, $urandom_range(0, 2));
            queue_line(txt, 1'($urandom), 0, 0, 0);
         end
         7: queue_line(txt, 1'($urandom), 1'($urandom), 1'($urandom), 0);
         default: begin
            text_bytes(txt, $urandom_range(1, 14));
            queue_line(txt, 1'($urandom), 1'($urandom), 1'($urandom), 1);
         end
      endcase
   endfunction

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_ch.valid || decoded_q.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_enable(bit v);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= v;
      do @(posedge clock); while (!csr_ch.ready);
      dec_enable = v;
      csr_ch.valid <= 1'b0;
   endtask

   task automatic random_phase(int n_items);
      int target;
      target = bytes_sent + pending_bytes.size() + n_items;
      while (bytes_sent + pending_bytes.size() < target) begin
         random_line();
         while (pending_bytes.size() > 20) @(posedge clock);
      end
      wait_drained();
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.last = 1'b0;
      req_ch.no_byte = 1'b0;
      req_ch.preset_valid = 1'b0;
      req_ch.preset_qp = 1'b0;
      req_ch.preset_b64 = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.data = 1'b0;
      shadow_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_enable(1'b1);
      queue_line('{}, 0, 0, 0, 0);
      queue_line('{8'h00, 8'hFF}, 0, 0, 0, 0);
      queue_str("=41=z1=4Z=FF=", 1, 1, 0);
      queue_str("a =?x?Q?h=3D?= b =?y?B?SGk=?= c\n", 0, 0, 0);
      queue_str("QUJDREVGR0hJSktM TQ==", 1, 0, 1);
      queue_str("Zm9v", 1, 0, 1);
      queue_str("x=4", 1, 1, 0);
      queue_str("end?", 0, 0, 0);
      wait_drained();

      write_enable(1'b0);
      queue_str("=41 =?x?Q?", 1, 1, 1);
      queue_line('{8'hFF, 8'h80, 8'h7F, 8'h01}, 0, 0, 0, 1);
      wait_drained();

      write_enable(1'b1);
      no_idle = 1'b1;
      random_phase(40);
      no_idle = 1'b0;
      write_enable(1'b0);
      random_phase(30);
      write_enable(1'b1);
      random_phase(100);
      stim_done = 1'b1;

      $display("covered %0d lines, %0d items sent, %0d results checked",
               lines_sent, bytes_sent, bytes_checked);
      $display("decode enable toggled both ways, presets, QP, base64 and encoded words");
      if (err_cnt == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
